// ===== rtl/core/mrm_pkg.sv =====
package mrm_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int LANES      = 4;
    localparam int LANE_W     = $clog2(LANES);
    localparam int INDEX_W    = 2 * LANE_W;
    localparam int PROD_W     = 2 * DATA_WIDTH;
    localparam int SUM_EXT    = $clog2(LANES);
    localparam int SUM_W      = PROD_W + SUM_EXT;
    localparam int TOP_W      = SUM_W - DATA_WIDTH + 1;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_ROW  = 1'b1;

    typedef struct packed {
        logic                              cmd;
        logic [INDEX_W-1:0]                load_index;
        logic [DATA_WIDTH-1:0]             load_value;
        logic [LANES-1:0][DATA_WIDTH-1:0]  row;
        logic [LANES-1:0][SUM_W-1:0]       sum;
    } t_item;

endpackage

// ===== rtl/core/mrm_cell.sv =====
module mrm_cell
    import mrm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [LANE_W-1:0] i_cell_idx,
    input  logic              i_valid,
    output logic              o_ready,
    input  t_item             i_item,
    output logic              o_valid,
    input  logic              i_ready,
    output t_item             o_item
);

    logic signed [DATA_WIDTH-1:0] r_coef [LANES];
    logic signed [DATA_WIDTH-1:0] row_k;
    logic signed [PROD_W-1:0]     n_prod [LANES];
    logic signed [PROD_W-1:0]     r_prod [LANES];
    logic                         r_a_valid;
    logic                         r_b_valid;
    t_item                        r_a_item;
    t_item                        r_b_item;
    t_item                        n_b_item;
    logic                         ready_a;
    logic                         ready_b;
    logic                         coef_wr;

    assign ready_b = !r_b_valid || i_ready;
    assign ready_a = !r_a_valid || ready_b;
    assign o_ready = ready_a;
    assign o_valid = r_b_valid;
    assign o_item  = r_b_item;

    assign row_k   = i_item.row[i_cell_idx];
    assign coef_wr = i_valid && ready_a && (i_item.cmd == CMD_LOAD)
                     && (i_item.load_index[LANE_W-1:0] == i_cell_idx);

    always_comb begin
        for (int j = 0; j < LANES; j++) begin
            n_prod[j] = row_k * r_coef[j];
        end
        n_b_item = r_a_item;
        for (int j = 0; j < LANES; j++) begin
            n_b_item.sum[j] = r_a_item.sum[j]
                              + {{SUM_EXT{r_prod[j][PROD_W-1]}}, r_prod[j]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            for (int j = 0; j < LANES; j++) begin
                r_coef[j] <= '0;
            end
        end else begin
            if (ready_a) begin
                r_a_valid <= i_valid;
            end
            if (ready_b) begin
                r_b_valid <= r_a_valid;
            end
            if (coef_wr) begin
                r_coef[i_item.load_index[INDEX_W-1:LANE_W]] <= i_item.load_value;
            end
        end
        if (i_valid && ready_a) begin
            r_a_item <= i_item;
            r_prod   <= n_prod;
        end
        if (r_a_valid && ready_b) begin
            r_b_item <= n_b_item;
        end
    end

endmodule

// ===== rtl/core/mrm_scale.sv =====
module mrm_scale
    import mrm_pkg::*;
(
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  t_item                            i_item,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [LANES-1:0][DATA_WIDTH-1:0] o_data
);

    logic                             r_valid;
    logic [LANES-1:0][DATA_WIDTH-1:0] r_data;
    logic [LANES-1:0][DATA_WIDTH-1:0] n_data;
    logic [SUM_W-1:0]                 shifted [LANES];
    logic [TOP_W-1:0]                 top_bits [LANES];
    logic                             ready_in;

    assign ready_in = !r_valid || i_ready;
    assign o_ready  = ready_in;
    assign o_valid  = r_valid;
    assign o_data   = r_data;

    always_comb begin
        for (int j = 0; j < LANES; j++) begin
            shifted[j]  = SUM_W'($signed(i_item.sum[j]) >>> FRAC_BITS);
            top_bits[j] = shifted[j][SUM_W-1:DATA_WIDTH-1];
            if ((top_bits[j] == '0) || (top_bits[j] == '1)) begin
                n_data[j] = shifted[j][DATA_WIDTH-1:0];
            end else if (shifted[j][SUM_W-1]) begin
                n_data[j] = {1'b1, {(DATA_WIDTH-1){1'b0}}};
            end else begin
                n_data[j] = {1'b0, {(DATA_WIDTH-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (ready_in) begin
            r_valid <= i_valid && (i_item.cmd == CMD_ROW);
        end
        if (i_valid && ready_in && (i_item.cmd == CMD_ROW)) begin
            r_data <= n_data;
        end
    end

endmodule

// ===== rtl/core/matrix_row_multiply_4x4.sv =====
// Channel   Handshake                   Payload
// input     i_in_valid / o_in_ready     i_cmd, i_load_index, i_load_value, i_row_x..i_row_w
// output    o_out_valid / i_out_ready   o_out_0..o_out_3
//
// One item per cycle while the output is not stalled; a row result passes four cells
// of two stages each, multiply then accumulate, plus the round and saturate register.
// Load items travel the chain and update a cell's coefficients as they pass it.
// Load items give no result and leave the chain after the last cell.
// Reset clears all coefficients to zero and empties the chain.
// Each stage holds while the stage after it is full and stalled.
module matrix_row_multiply_4x4
    import mrm_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_cmd,
    input  logic [INDEX_W-1:0]           i_load_index,
    input  logic signed [DATA_WIDTH-1:0] i_load_value,
    input  logic signed [DATA_WIDTH-1:0] i_row_x,
    input  logic signed [DATA_WIDTH-1:0] i_row_y,
    input  logic signed [DATA_WIDTH-1:0] i_row_z,
    input  logic signed [DATA_WIDTH-1:0] i_row_w,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [DATA_WIDTH-1:0] o_out_0,
    output logic signed [DATA_WIDTH-1:0] o_out_1,
    output logic signed [DATA_WIDTH-1:0] o_out_2,
    output logic signed [DATA_WIDTH-1:0] o_out_3
);

    t_item                            chain_item  [LANES+1];
    logic                             chain_valid [LANES+1];
    logic                             chain_ready [LANES+1];
    logic [LANES-1:0][DATA_WIDTH-1:0] out_data;

    always_comb begin
        chain_item[0].cmd        = i_cmd;
        chain_item[0].load_index = i_load_index;
        chain_item[0].load_value = i_load_value;
        chain_item[0].row[0]     = i_row_x;
        chain_item[0].row[1]     = i_row_y;
        chain_item[0].row[2]     = i_row_z;
        chain_item[0].row[3]     = i_row_w;
        chain_item[0].sum        = '0;
    end

    assign chain_valid[0] = i_in_valid;
    assign o_in_ready     = chain_ready[0];

    for (genvar g = 0; g < LANES; g++) begin : g_cell
        mrm_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cell_idx (LANE_W'(g)),
            .i_valid    (chain_valid[g]),
            .o_ready    (chain_ready[g]),
            .i_item     (chain_item[g]),
            .o_valid    (chain_valid[g+1]),
            .i_ready    (chain_ready[g+1]),
            .o_item     (chain_item[g+1])
        );
    end

    mrm_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (chain_valid[LANES]),
        .o_ready (chain_ready[LANES]),
        .i_item  (chain_item[LANES]),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (out_data)
    );

    assign o_out_0 = out_data[0];
    assign o_out_1 = out_data[1];
    assign o_out_2 = out_data[2];
    assign o_out_3 = out_data[3];

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("input stalled while output is free");

    a_chain_full_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (chain_valid[1] && chain_valid[LANES]))
        else $error("input stalled with empty cells");

endmodule

// ===== bench/matrix_row_multiply_4x4_checker.sv =====
module matrix_row_multiply_4x4_checker
    import mrm_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_ready,
    input  logic                         i_cmd,
    input  logic [INDEX_W-1:0]           i_load_index,
    input  logic signed [DATA_WIDTH-1:0] i_load_value,
    input  logic signed [DATA_WIDTH-1:0] i_row_x,
    input  logic signed [DATA_WIDTH-1:0] i_row_y,
    input  logic signed [DATA_WIDTH-1:0] i_row_z,
    input  logic signed [DATA_WIDTH-1:0] i_row_w,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  logic signed [DATA_WIDTH-1:0] i_out_0,
    input  logic signed [DATA_WIDTH-1:0] i_out_1,
    input  logic signed [DATA_WIDTH-1:0] i_out_2,
    input  logic signed [DATA_WIDTH-1:0] i_out_3,
    output int                           o_mismatches,
    output int                           o_rows_pending
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [LANES-1:0][DATA_WIDTH-1:0] t_lanes;

    logic signed [DATA_WIDTH-1:0] coef_mem [LANES*LANES];
    t_lanes                       expected_rows [$];
    int                           mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    initial o_rows_pending = 0;

    function automatic logic [DATA_WIDTH-1:0] lane_dot(input t_lanes row_in, input int lane);
        logic signed [SUM_W-1:0] acc;
        logic signed [SUM_W-1:0] scaled;
        acc = '0;
        for (int k = 0; k < LANES; k++) begin
            acc = acc + $signed(row_in[k]) * coef_mem[LANES * lane + k];
        end
        scaled = acc >>> FRAC_BITS;
        if (&scaled[SUM_W-1:DATA_WIDTH-1] || ~|scaled[SUM_W-1:DATA_WIDTH-1]) begin
            return scaled[DATA_WIDTH-1:0];
        end else if (scaled[SUM_W-1]) begin
            return {1'b1, {(DATA_WIDTH-1){1'b0}}};
        end else begin
            return {1'b0, {(DATA_WIDTH-1){1'b1}}};
        end
    endfunction

    always @(posedge i_clk) begin
        t_lanes row_in;
        t_lanes got;
        t_lanes want;
        if (!i_rst_n) begin
            foreach (coef_mem[i]) coef_mem[i] = '0;
            expected_rows.delete();
        end else begin
            // check the result side first so an item accepted this edge is not matched
            if (i_out_valid && i_out_ready) begin
                got = {i_out_3, i_out_2, i_out_1, i_out_0};
                if (expected_rows.size() == 0) begin
                    $error("result with no row pending: out_0 %0d out_1 %0d out_2 %0d out_3 %0d",
                           i_out_0, i_out_1, i_out_2, i_out_3);
                    mismatch_count++;
                end else begin
                    want = expected_rows.pop_front();
                    for (int j = 0; j < LANES; j++) begin
                        if (got[j] !== want[j]) begin
                            $error("out_%0d mismatch: expected %0d, actual %0d",
                                   j, $signed(want[j]), $signed(got[j]));
                            mismatch_count++;
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_cmd == CMD_LOAD) begin
                    coef_mem[i_load_index] = i_load_value;
                end else begin
                    row_in = {i_row_w, i_row_z, i_row_y, i_row_x};
                    for (int j = 0; j < LANES; j++) begin
                        want[j] = lane_dot(row_in, j);
                    end
                    expected_rows.push_back(want);
                end
            end
        end
        o_rows_pending <= expected_rows.size();
    end

endmodule

// ===== bench/matrix_row_multiply_4x4_test.sv =====
module matrix_row_multiply_4x4_test
    import mrm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES      = 200000;
    localparam int RANDOM_ITEMS      = 1030;
    localparam int IDLE_PCT          = 8;
    localparam int LOAD_PCT          = 20;
    localparam int LONG_STALL_AT     = 300;
    localparam int LONG_STALL_CYCLES = 120;
    localparam int CALM_FROM         = 550;
    localparam int CALM_TO           = 750;
    localparam int PAUSE_AT          = 850;
    localparam int DRAIN_CYCLES      = 20;

    localparam logic [DATA_WIDTH-1:0] Q_MAX  = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] Q_MIN  = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic [DATA_WIDTH-1:0] Q_ONE  = DATA_WIDTH'(1) << FRAC_BITS;
    localparam logic [DATA_WIDTH-1:0] Q_HALF = DATA_WIDTH'(1) << (FRAC_BITS - 1);
    localparam logic [DATA_WIDTH-1:0] Q_LSB  = DATA_WIDTH'(1);
    localparam logic [DATA_WIDTH-1:0] Q_NLSB = '1;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_in_valid;
    logic                         o_in_ready;
    logic                         i_cmd;
    logic [INDEX_W-1:0]           i_load_index;
    logic signed [DATA_WIDTH-1:0] i_load_value;
    logic signed [DATA_WIDTH-1:0] i_row_x;
    logic signed [DATA_WIDTH-1:0] i_row_y;
    logic signed [DATA_WIDTH-1:0] i_row_z;
    logic signed [DATA_WIDTH-1:0] i_row_w;
    logic                         o_out_valid;
    logic                         i_out_ready;
    logic signed [DATA_WIDTH-1:0] o_out_0;
    logic signed [DATA_WIDTH-1:0] o_out_1;
    logic signed [DATA_WIDTH-1:0] o_out_2;
    logic signed [DATA_WIDTH-1:0] o_out_3;

    int mismatches;
    int rows_pending;
    int items_sent     = 0;
    int cycle_count    = 0;
    bit long_hold_done = 1'b0;

    matrix_row_multiply_4x4 dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_cmd        (i_cmd),
        .i_load_index (i_load_index),
        .i_load_value (i_load_value),
        .i_row_x      (i_row_x),
        .i_row_y      (i_row_y),
        .i_row_z      (i_row_z),
        .i_row_w      (i_row_w),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_0      (o_out_0),
        .o_out_1      (o_out_1),
        .o_out_2      (o_out_2),
        .o_out_3      (o_out_3)
    );

    matrix_row_multiply_4x4_checker checker_inst (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_cmd          (i_cmd),
        .i_load_index   (i_load_index),
        .i_load_value   (i_load_value),
        .i_row_x        (i_row_x),
        .i_row_y        (i_row_y),
        .i_row_z        (i_row_z),
        .i_row_w        (i_row_w),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_out_0        (o_out_0),
        .i_out_1        (o_out_1),
        .i_out_2        (o_out_2),
        .i_out_3        (o_out_3),
        .o_mismatches   (mismatches),
        .o_rows_pending (rows_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic bit calm_stretch();
        return items_sent >= CALM_FROM && items_sent < CALM_TO;
    endfunction

    function automatic logic [DATA_WIDTH-1:0] rand_fixed();
        logic [DATA_WIDTH-1:0] r;
        r = $urandom;
        case ($urandom_range(9))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return '0;
            3, 4, 5: return {{(DATA_WIDTH-20){r[19]}}, r[19:0]};
            default: return r;
        endcase
    endfunction

    task automatic offer_item(input logic cmd, input logic [INDEX_W-1:0] idx,
                              input logic [DATA_WIDTH-1:0] val,
                              input logic [DATA_WIDTH-1:0] x, input logic [DATA_WIDTH-1:0] y,
                              input logic [DATA_WIDTH-1:0] z, input logic [DATA_WIDTH-1:0] w);
        if (!calm_stretch() && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_cmd        <= cmd;
        i_load_index <= idx;
        i_load_value <= val;
        i_row_x      <= x;
        i_row_y      <= y;
        i_row_z      <= z;
        i_row_w      <= w;
        i_in_valid   <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
    endtask

    task automatic load_coef(input int idx, input logic [DATA_WIDTH-1:0] val);
        offer_item(CMD_LOAD, INDEX_W'(idx), val, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic send_row(input logic [DATA_WIDTH-1:0] x, input logic [DATA_WIDTH-1:0] y,
                            input logic [DATA_WIDTH-1:0] z, input logic [DATA_WIDTH-1:0] w);
        offer_item(CMD_ROW, INDEX_W'($urandom_range(15)), $urandom, x, y, z, w);
    endtask

    task automatic drain_rows();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (rows_pending != 0) @(posedge i_clk);
    endtask

    // result side: random stalls, one long hold-off, and a stall-free stretch
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!long_hold_done && items_sent >= LONG_STALL_AT) begin
                long_hold_done = 1'b1;
                i_out_ready <= 1'b0;
                repeat (LONG_STALL_CYCLES) @(posedge i_clk);
            end
            i_out_ready <= calm_stretch() || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_cmd        = CMD_LOAD;
        i_load_index = '0;
        i_load_value = '0;
        i_row_x      = '0;
        i_row_y      = '0;
        i_row_z      = '0;
        i_row_w      = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero coefficients after reset
        send_row(Q_MAX, Q_MIN, Q_NLSB, Q_LSB);
        // identity matrix
        load_coef(0, Q_ONE);
        load_coef(5, Q_ONE);
        load_coef(10, Q_ONE);
        load_coef(15, Q_ONE);
        send_row(Q_LSB, Q_NLSB, Q_MAX, Q_MIN);
        // floor rounding on a half LSB
        load_coef(0, Q_HALF);
        send_row(Q_LSB, '0, '0, '0);
        send_row(Q_NLSB, '0, '0, '0);
        // saturation both ways
        for (int k = 0; k < LANES; k++) load_coef(k, Q_MAX);
        send_row(Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        send_row(Q_MIN, Q_MIN, Q_MIN, Q_MIN);
        for (int k = LANES; k < 2 * LANES; k++) load_coef(k, Q_MIN);
        send_row(Q_MIN, Q_MIN, Q_MIN, Q_MIN);
        load_coef(15, '0);
        send_row(Q_ONE, Q_ONE, Q_ONE, Q_ONE);
        drain_rows();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == PAUSE_AT) drain_rows();
            if ($urandom_range(99) < LOAD_PCT) begin
                load_coef($urandom_range(15), rand_fixed());
            end else begin
                send_row(rand_fixed(), rand_fixed(), rand_fixed(), rand_fixed());
            end
        end

        drain_rows();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== matrix_row_multiply_4x4.f =====
rtl/core/mrm_pkg.sv
rtl/core/mrm_cell.sv
rtl/core/mrm_scale.sv
rtl/core/matrix_row_multiply_4x4.sv
bench/matrix_row_multiply_4x4_checker.sv
bench/matrix_row_multiply_4x4_test.sv
